[sv/hslrgb_pkg.sv]
// Shared types, constants and helpers for the HSL to RGB pixel converter.
// Depends on nothing; hslrgb_hue, hslrgb_byte and hsl_to_rgb_pixel use it.
package hslrgb_pkg;

  // Unsigned fixed point with 16 fraction bits: 1.0 needs 17 bits.
  localparam int unsigned FX_W   = 17;
  // L + S and 2 * L reach 2.0, so var1, var2 and their difference use this width.
  localparam int unsigned VAR_W  = 18;
  // Signed hue argument before wrapping.
  localparam int unsigned VH_W   = 19;
  // Product of the difference and the hue ramp coefficient.
  localparam int unsigned PROD_W = VAR_W + FX_W;
  // Channel value after the ramp has been added to var1.
  localparam int unsigned CH_W   = 21;

  localparam logic [FX_W-1:0]        FX_ONE        = 17'd65536;
  localparam logic [FX_W-1:0]        FX_HALF       = 17'd32768;
  localparam logic signed [VH_W-1:0] FX_THIRD_S    = 19'sd21845;
  localparam logic signed [VH_W-1:0] FX_ONE_S      = 19'sd65536;
  localparam logic [FX_W-1:0]        FX_TWO_THIRDS = 17'd43691;

  // Hue rule thresholds on the wrapped argument u:
  // 6u < 1.0 holds for u below one sixth, 2u < 1.0 below one half,
  // 3u < 2.0 below two thirds (all rounded up to the first failing code).
  localparam logic [FX_W-1:0] HUE_SIXTH_LIM = 17'd10923;
  localparam logic [FX_W-1:0] HUE_HALF_LIM  = 17'd32768;
  localparam logic [FX_W-1:0] HUE_TWO3_LIM  = 17'd43691;

  typedef enum logic [1:0] {
    HUE_SEL_V1,
    HUE_SEL_V2,
    HUE_SEL_MUL
  } hue_sel_t;

  // What one channel does in the later stages: which term it takes and,
  // for the ramp, the coefficient that multiplies var2 - var1.
  typedef struct packed {
    hue_sel_t        sel;
    logic [FX_W-1:0] coef;
  } hue_term_t;

  // Byte to fixed point with rounding: b * 65536 / 255 equals b * 257 plus
  // a fraction that rounds up exactly when the top bit of b is set.
  function automatic logic [FX_W-1:0] to_fixed(input logic [7:0] b);
    logic [FX_W-1:0] v;
    v = {1'b0, b, b} + {16'd0, b[7]};
    return v;
  endfunction

endpackage

[sv/hslrgb_hue.sv]
// Hue rule decoder for one colour channel: wraps the hue argument and picks
// the term and ramp coefficient. Depends on hslrgb_pkg.
module hslrgb_hue (
  input  logic signed [hslrgb_pkg::VH_W-1:0] vh_i,
  output hslrgb_pkg::hue_term_t              term_o
);

  logic signed [hslrgb_pkg::VH_W-1:0] vh_pos;
  logic signed [hslrgb_pkg::VH_W-1:0] vh_wrap;
  logic [hslrgb_pkg::FX_W-1:0]        u;
  logic [hslrgb_pkg::FX_W-1:0]        down;
  logic [hslrgb_pkg::FX_W+1:0]        up6;
  logic [hslrgb_pkg::FX_W+1:0]        down6;

  always_comb begin
    vh_pos  = (vh_i < 0) ? (vh_i + hslrgb_pkg::FX_ONE_S) : vh_i;
    // An argument of exactly one turn is kept as it is.
    vh_wrap = (vh_pos > hslrgb_pkg::FX_ONE_S) ? (vh_pos - hslrgb_pkg::FX_ONE_S) : vh_pos;
    u       = vh_wrap[hslrgb_pkg::FX_W-1:0];
    down    = hslrgb_pkg::FX_TWO_THIRDS - u;
    up6     = {u, 2'b00} + {1'b0, u, 1'b0};
    down6   = {down, 2'b00} + {1'b0, down, 1'b0};

    if (u < hslrgb_pkg::HUE_SIXTH_LIM) begin
      term_o.sel  = hslrgb_pkg::HUE_SEL_MUL;
      term_o.coef = up6[hslrgb_pkg::FX_W-1:0];
    end else if (u < hslrgb_pkg::HUE_HALF_LIM) begin
      term_o.sel  = hslrgb_pkg::HUE_SEL_V2;
      term_o.coef = '0;
    end else if (u < hslrgb_pkg::HUE_TWO3_LIM) begin
      term_o.sel  = hslrgb_pkg::HUE_SEL_MUL;
      term_o.coef = down6[hslrgb_pkg::FX_W-1:0];
    end else begin
      term_o.sel  = hslrgb_pkg::HUE_SEL_V1;
      term_o.coef = '0;
    end
  end

endmodule

[sv/hslrgb_byte.sv]
// Channel output for one colour: chooses the term, adds the rounded ramp,
// scales to a byte with rounding and saturates. Depends on hslrgb_pkg.
module hslrgb_byte (
  input  hslrgb_pkg::hue_sel_t              sel_i,
  input  logic [hslrgb_pkg::PROD_W-1:0]     prod_i,
  input  logic [hslrgb_pkg::VAR_W-1:0]      var1_i,
  input  logic [hslrgb_pkg::VAR_W-1:0]      var2_i,
  input  logic [hslrgb_pkg::FX_W-1:0]       light_i,
  input  logic                              sat_zero_i,
  output logic [7:0]                        byte_o
);

  logic [hslrgb_pkg::PROD_W-1:0] prod_rnd;
  logic [hslrgb_pkg::CH_W-1:0]   ch;
  logic [hslrgb_pkg::CH_W+8:0]   scaled;
  logic [13:0]                   whole;

  always_comb begin
    prod_rnd = prod_i + hslrgb_pkg::PROD_W'(hslrgb_pkg::FX_HALF);
    case (sel_i)
      hslrgb_pkg::HUE_SEL_MUL:
        ch = hslrgb_pkg::CH_W'(var1_i) + hslrgb_pkg::CH_W'(prod_rnd[hslrgb_pkg::PROD_W-1:16]);
      hslrgb_pkg::HUE_SEL_V2: ch = hslrgb_pkg::CH_W'(var2_i);
      hslrgb_pkg::HUE_SEL_V1: ch = hslrgb_pkg::CH_W'(var1_i);
      default:                ch = hslrgb_pkg::CH_W'(var1_i);
    endcase
    // With no saturation the pixel is grey at the input lightness.
    if (sat_zero_i) begin
      ch = hslrgb_pkg::CH_W'(light_i);
    end
    // Times 255 is a shift and a subtract.
    scaled = {1'b0, ch, 8'd0} - (hslrgb_pkg::CH_W+9)'(ch)
             + (hslrgb_pkg::CH_W+9)'(hslrgb_pkg::FX_HALF);
    whole  = scaled[hslrgb_pkg::CH_W+8:16];
    byte_o = (whole > 14'd255) ? 8'd255 : whole[7:0];
  end

endmodule

[sv/hsl_to_rgb_pixel.sv]
// Top level of the HSL to RGB pixel converter: four-stage pipeline with
// valid/ready flow control. Depends on hslrgb_pkg, hslrgb_hue, hslrgb_byte.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_ready   | in_hue, in_saturation, in_lightness
//   out_    | output    | out_valid/out_ready | out_red, out_green, out_blue
//
// One pixel can be taken in every cycle while the output side is ready. A pixel
// passes on its way out through the four register stages:
// lightness times saturation, var1/var2 and hue decode, the three ramp
// multipliers, and the byte scaling into the output register.
// Reset is synchronous and active low; it clears only the stage valid bits.
// A stall at the output holds only the unbroken run of occupied stages before it;
// earlier data moves into gaps, so input is refused only when the whole pipe is full.
module hsl_to_rgb_pixel (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_hue,
  input  logic [7:0] in_saturation,
  input  logic [7:0] in_lightness,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  localparam int unsigned FX_W   = hslrgb_pkg::FX_W;
  localparam int unsigned VAR_W  = hslrgb_pkg::VAR_W;
  localparam int unsigned VH_W   = hslrgb_pkg::VH_W;
  localparam int unsigned PROD_W = hslrgb_pkg::PROD_W;

  // Stage ready chain: a stage takes new data when it is empty or its
  // contents move on in the same cycle.
  logic rdy1, rdy2, rdy3, rdy4;

  // Stage 1: fixed-point inputs and the rounded product L*S.
  logic              vld1_r;
  logic [FX_W-1:0]   hue1_r, sat1_r, light1_r, ls1_r;
  logic [FX_W-1:0]   hue1_nxt, sat1_nxt, light1_nxt, ls1_nxt;
  logic [2*FX_W-1:0] ls_prod;

  // Stage 2: var1, var2, their difference and the per-channel hue decode.
  logic                  vld2_r;
  logic [VAR_W-1:0]      var1_2_r, var2_2_r, diff2_r;
  logic [VAR_W-1:0]      var1_2_nxt, var2_2_nxt, diff2_nxt;
  logic [FX_W-1:0]       light2_r;
  logic                  szero2_r;
  hslrgb_pkg::hue_term_t term2_r   [3];
  hslrgb_pkg::hue_term_t term2_nxt [3];
  logic [VAR_W-1:0]      l_plus_s, two_l;
  logic signed [VH_W-1:0] vh [3];

  // Stage 3: ramp products, one multiplier per channel.
  logic                  vld3_r;
  logic [PROD_W-1:0]     prod3_r   [3];
  logic [PROD_W-1:0]     prod3_nxt [3];
  hslrgb_pkg::hue_sel_t  sel3_r    [3];
  logic [VAR_W-1:0]      var1_3_r, var2_3_r;
  logic [FX_W-1:0]       light3_r;
  logic                  szero3_r;

  // Stage 4: output register.
  logic                  vld4_r;
  logic [7:0]            byte4_r   [3];
  logic [7:0]            byte4_nxt [3];

  assign rdy4     = !vld4_r || out_ready;
  assign rdy3     = !vld3_r || rdy4;
  assign rdy2     = !vld2_r || rdy3;
  assign rdy1     = !vld1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      if (rdy1) vld1_r <= in_valid;
      if (rdy2) vld2_r <= vld1_r;
      if (rdy3) vld3_r <= vld2_r;
      if (rdy4) vld4_r <= vld3_r;
    end
  end

  // ---------------- Stage 1 ----------------
  always_comb begin
    hue1_nxt   = hslrgb_pkg::to_fixed(in_hue);
    sat1_nxt   = hslrgb_pkg::to_fixed(in_saturation);
    light1_nxt = hslrgb_pkg::to_fixed(in_lightness);
    ls_prod    = (2*FX_W)'(light1_nxt) * (2*FX_W)'(sat1_nxt)
                 + (2*FX_W)'(hslrgb_pkg::FX_HALF);
    ls1_nxt    = ls_prod[FX_W+15:16];
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      hue1_r   <= hue1_nxt;
      sat1_r   <= sat1_nxt;
      light1_r <= light1_nxt;
      ls1_r    <= ls1_nxt;
    end
  end

  // ---------------- Stage 2 ----------------
  always_comb begin
    l_plus_s = VAR_W'(light1_r) + VAR_W'(sat1_r);
    two_l    = {light1_r, 1'b0};
    if (light1_r < hslrgb_pkg::FX_HALF) begin
      var2_2_nxt = VAR_W'(light1_r) + VAR_W'(ls1_r);
    end else begin
      var2_2_nxt = (l_plus_s >= VAR_W'(ls1_r)) ? (l_plus_s - VAR_W'(ls1_r)) : '0;
    end
    var1_2_nxt = (two_l >= var2_2_nxt) ? (two_l - var2_2_nxt) : '0;
    diff2_nxt  = (var2_2_nxt >= var1_2_nxt) ? (var2_2_nxt - var1_2_nxt) : '0;
    // Red, green and blue look at the hue one third ahead, on, and behind.
    vh[0] = $signed(VH_W'(hue1_r)) + hslrgb_pkg::FX_THIRD_S;
    vh[1] = $signed(VH_W'(hue1_r));
    vh[2] = $signed(VH_W'(hue1_r)) - hslrgb_pkg::FX_THIRD_S;
  end

  for (genvar c = 0; c < 3; c++) begin : g_hue
    hslrgb_hue u_hue (
      .vh_i   (vh[c]),
      .term_o (term2_nxt[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      var1_2_r <= var1_2_nxt;
      var2_2_r <= var2_2_nxt;
      diff2_r  <= diff2_nxt;
      light2_r <= light1_r;
      szero2_r <= (sat1_r == '0);
      term2_r  <= term2_nxt;
    end
  end

  // ---------------- Stage 3 ----------------
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod3_nxt[c] = PROD_W'(diff2_r) * PROD_W'(term2_r[c].coef);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      prod3_r  <= prod3_nxt;
      for (int c = 0; c < 3; c++) begin
        sel3_r[c] <= term2_r[c].sel;
      end
      var1_3_r <= var1_2_r;
      var2_3_r <= var2_2_r;
      light3_r <= light2_r;
      szero3_r <= szero2_r;
    end
  end

  // ---------------- Stage 4 ----------------
  for (genvar c = 0; c < 3; c++) begin : g_byte
    hslrgb_byte u_byte (
      .sel_i      (sel3_r[c]),
      .prod_i     (prod3_r[c]),
      .var1_i     (var1_3_r),
      .var2_i     (var2_3_r),
      .light_i    (light3_r),
      .sat_zero_i (szero3_r),
      .byte_o     (byte4_nxt[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      byte4_r <= byte4_nxt;
    end
  end

  assign out_valid = vld4_r;
  assign out_red   = byte4_r[0];
  assign out_green = byte4_r[1];
  assign out_blue  = byte4_r[2];

endmodule

[sv/hslrgb_checker.sv]
// Port-level checks for the HSL to RGB pixel converter, bound to its top.
// Depends on hsl_to_rgb_pixel only through the bind at the end of the file.
module hslrgb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // A ready output side never back-pressures the input.
  a_ready_flows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input refused although the output side is ready");

  // Ready cycles with no input transfer, enough to pass every stage, drain the pipeline.
  a_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(in_xfer, 1) && !$past(in_xfer, 2) && !$past(in_xfer, 3) &&
     !$past(in_xfer, 4) && $past(out_ready, 1) && $past(out_ready, 2) &&
     $past(out_ready, 3) && $past(out_ready, 4)) |-> !out_valid)
    else $error("result appeared with no pixel transferred in");

  // A stalled result stays offered and unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue)))
    else $error("stalled result changed or was withdrawn");

endmodule

bind hsl_to_rgb_pixel hslrgb_checker u_hslrgb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue)
);
